// ----- hw/rtl/jsv_pkg.sv -----
// shared types and constants for the json syntax validator
// no dependencies; used by jsv_step and json_syntax_validator
package jsv_pkg;

  localparam int MAX_DEPTH   = 32;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH);
  localparam int LEVEL_W     = $clog2(MAX_DEPTH + 1);
  localparam int OFFSET_BITS = 24;

  localparam logic [LEVEL_W-1:0]     LEVEL_MAX  = LEVEL_W'(MAX_DEPTH);
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // parser phases
  localparam logic [4:0] P_VALUE          = 5'd0;
  localparam logic [4:0] P_VALUE_OR_CLOSE = 5'd1;
  localparam logic [4:0] P_KEY_OR_CLOSE   = 5'd2;
  localparam logic [4:0] P_KEY            = 5'd3;
  localparam logic [4:0] P_COLON          = 5'd4;
  localparam logic [4:0] P_AFTER          = 5'd5;
  localparam logic [4:0] P_STR            = 5'd6;
  localparam logic [4:0] P_STR_ESC        = 5'd7;
  localparam logic [4:0] P_STR_HEX        = 5'd8;
  localparam logic [4:0] P_KSTR           = 5'd9;
  localparam logic [4:0] P_KSTR_ESC       = 5'd10;
  localparam logic [4:0] P_KSTR_HEX       = 5'd11;
  localparam logic [4:0] P_NUM_MINUS      = 5'd12;
  localparam logic [4:0] P_NUM_ZERO       = 5'd13;
  localparam logic [4:0] P_NUM_INT        = 5'd14;
  localparam logic [4:0] P_NUM_DOT        = 5'd15;
  localparam logic [4:0] P_NUM_FRAC       = 5'd16;
  localparam logic [4:0] P_NUM_E          = 5'd17;
  localparam logic [4:0] P_NUM_ESIGN      = 5'd18;
  localparam logic [4:0] P_NUM_EXP        = 5'd19;
  localparam logic [4:0] P_LIT_TRUE       = 5'd20;
  localparam logic [4:0] P_LIT_FALSE      = 5'd21;
  localparam logic [4:0] P_LIT_NULL       = 5'd22;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_EARLY_END  = 4'd1;
  localparam logic [3:0] ERR_UNEXPECTED = 4'd2;
  localparam logic [3:0] ERR_CONTROL    = 4'd3;
  localparam logic [3:0] ERR_ESCAPE     = 4'd4;
  localparam logic [3:0] ERR_HEX        = 4'd5;
  localparam logic [3:0] ERR_NON_ASCII  = 4'd6;
  localparam logic [3:0] ERR_NUMBER     = 4'd7;
  localparam logic [3:0] ERR_TRAILING   = 4'd8;
  localparam logic [3:0] ERR_TOO_DEEP   = 4'd9;

  typedef struct packed {
    logic [4:0]             phase;
    logic [LEVEL_W-1:0]     level;
    logic [1:0]             hex_count;
    logic [15:0]            hex_value;
    logic [2:0]             lit_index;
    logic [3:0]             err;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] err_offset;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      P_VALUE,
    level:      '0,
    hex_count:  '0,
    hex_value:  '0,
    lit_index:  '0,
    err:        ERR_NONE,
    offset:     '0,
    err_offset: '0
  };

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
    logic [23:0] offset;
  } result_t;

  typedef struct packed {
    logic en;
    logic kind;
  } push_t;

endpackage

// ----- hw/rtl/json_syntax_validator.sv -----
// top level of the json syntax validator: byte input register, parser state,
// nesting stack and result register; depends on jsv_pkg and jsv_step
//
// usage:
//   the input channel (in_valid, in_ready, text_byte, last_byte) carries one
//   document byte per transfer; last_byte marks the final byte of a document.
//   the output channel (out_valid, out_ready, document_valid, error_code,
//   error_offset) carries one status per document, nothing for other bytes.
//   a byte transferred into the input register is parsed there by the
//   combinational step logic and, if it is the last byte, its status is
//   registered in the result register. one byte per cycle is sustained
//   while no last byte waits for the result register; the state update and
//   one push or pop of the 32-entry nesting stack happen in the cycle a byte is parsed.
//   the next document may start right after a last byte.
//   if the receiver stalls, the pending status holds and the input keeps
//   taking bytes until the next last byte needs the result register.
//   reset clears the parser state, the pipeline valids and the result valid;
//   the stack contents are not cleared, only entries pushed are ever read.
module json_syntax_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        document_valid,
  output logic [3:0]  error_code,
  output logic [23:0] error_offset
);

  logic                          s1_valid;
  logic [7:0]                    s1_byte;
  logic                          s1_last;
  logic                          s1_go;
  logic                          out_free;

  jsv_pkg::state_t               st;
  jsv_pkg::state_t               st_next;
  jsv_pkg::push_t                push;
  jsv_pkg::result_t              res;

  logic [jsv_pkg::MAX_DEPTH-1:0] stack;
  logic [jsv_pkg::DEPTH_W-1:0]   top_idx;
  logic                          top_kind;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_go;

  assign top_idx  = st.level[jsv_pkg::DEPTH_W-1:0] - 1'b1;
  assign top_kind = stack[top_idx];

  jsv_step u_step (
    .st        (st),
    .top_kind  (top_kind),
    .text_byte (s1_byte),
    .last_byte (s1_last),
    .nx        (st_next),
    .push      (push),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= text_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jsv_pkg::ST_RESET;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  // push writes at the current level, which is below the depth limit
  always_ff @(posedge clk) begin
    if (s1_go && push.en) begin
      stack[st.level[jsv_pkg::DEPTH_W-1:0]] <= push.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      document_valid <= res.valid;
      error_code     <= res.code;
      error_offset   <= res.offset;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    st.level <= jsv_pkg::LEVEL_MAX)
    else $error("nesting level beyond stack depth");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (st.phase == jsv_pkg::P_VALUE && st.level == '0 &&
                            st.err == jsv_pkg::ERR_NONE))
    else $error("parser not restarted after last byte");

  a_sticky_err: assert property (@(posedge clk) disable iff (rst)
    (st.err != jsv_pkg::ERR_NONE && !(s1_go && s1_last)) |=>
      (st.err == $past(st.err) && st.err_offset == $past(st.err_offset)))
    else $error("first error overwritten");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (document_valid == (error_code == jsv_pkg::ERR_NONE)))
    else $error("status flag disagrees with error code");

endmodule

// ----- hw/rtl/jsv_step.sv -----
// next-state logic of the validator for one document byte
// depends on jsv_pkg (state_t, result_t, push_t, phases, error codes)
module jsv_step (
  input  jsv_pkg::state_t  st,
  input  logic             top_kind,
  input  logic [7:0]       text_byte,
  input  logic             last_byte,
  output jsv_pkg::state_t  nx,
  output jsv_pkg::push_t   push,
  output jsv_pkg::result_t res
);

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case ({kind, idx})
      {2'd0, 3'd1}: c = 8'h72; // r
      {2'd0, 3'd2}: c = 8'h75; // u
      {2'd0, 3'd3}: c = 8'h65; // e
      {2'd1, 3'd1}: c = 8'h61; // a
      {2'd1, 3'd2}: c = 8'h6c; // l
      {2'd1, 3'd3}: c = 8'h73; // s
      {2'd1, 3'd4}: c = 8'h65; // e
      {2'd2, 3'd1}: c = 8'h75; // u
      {2'd2, 3'd2}: c = 8'h6c; // l
      {2'd2, 3'd3}: c = 8'h6c; // l
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  logic                          ws;
  logic                          dig;
  logic                          do_start;
  logic                          do_after;
  logic                          key_str;
  logic [4:0]                    str_base;
  logic [4:0]                    str_done;
  logic [4:0]                    hx;
  logic [15:0]                   hex_shift;
  logic [1:0]                    lit_kind;
  logic [2:0]                    lit_len;
  logic                          done;
  jsv_pkg::state_t               w;

  assign ws  = is_ws(text_byte);
  assign dig = is_digit(text_byte);
  assign hx  = hex_digit(text_byte);
  assign hex_shift = {st.hex_value[11:0], hx[3:0]};

  always_comb begin
    w         = st;
    push      = '0;
    do_start  = 1'b0;
    do_after  = 1'b0;
    key_str   = (st.phase == jsv_pkg::P_KSTR) || (st.phase == jsv_pkg::P_KSTR_ESC) ||
                (st.phase == jsv_pkg::P_KSTR_HEX);
    str_base  = key_str ? jsv_pkg::P_KSTR : jsv_pkg::P_STR;
    str_done  = key_str ? jsv_pkg::P_COLON : jsv_pkg::P_AFTER;
    lit_kind  = 2'(st.phase - jsv_pkg::P_LIT_TRUE);
    lit_len   = (lit_kind == 2'd1) ? 3'd5 : 3'd4;

    // bytes after the first error are only counted
    if (st.err == jsv_pkg::ERR_NONE) begin
      unique case (st.phase) inside
        jsv_pkg::P_VALUE: begin
          if (!ws) do_start = 1'b1;
        end
        jsv_pkg::P_VALUE_OR_CLOSE: begin
          if (!ws) begin
            if (text_byte == 8'h5d) begin
              w.level = st.level - 1'b1;
              w.phase = jsv_pkg::P_AFTER;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        jsv_pkg::P_KEY_OR_CLOSE, jsv_pkg::P_KEY: begin
          if (!ws) begin
            if (text_byte == 8'h22) begin
              w.phase = jsv_pkg::P_KSTR;
            end else if (text_byte == 8'h7d && st.phase == jsv_pkg::P_KEY_OR_CLOSE) begin
              w.level = st.level - 1'b1;
              w.phase = jsv_pkg::P_AFTER;
            end else begin
              w.err = jsv_pkg::ERR_UNEXPECTED;
            end
          end
        end
        jsv_pkg::P_COLON: begin
          if (!ws) begin
            if (text_byte == 8'h3a) w.phase = jsv_pkg::P_VALUE;
            else                    w.err   = jsv_pkg::ERR_UNEXPECTED;
          end
        end
        jsv_pkg::P_AFTER: begin
          do_after = 1'b1;
        end
        jsv_pkg::P_STR, jsv_pkg::P_KSTR: begin
          if (text_byte == 8'h22)      w.phase = str_done;
          else if (text_byte == 8'h5c) w.phase = str_base + 5'd1;
          else if (text_byte < 8'h20)  w.err   = jsv_pkg::ERR_CONTROL;
        end
        jsv_pkg::P_STR_ESC, jsv_pkg::P_KSTR_ESC: begin
          if (text_byte == 8'h22 || text_byte == 8'h5c || text_byte == 8'h2f ||
              text_byte == 8'h62 || text_byte == 8'h66 || text_byte == 8'h6e ||
              text_byte == 8'h72 || text_byte == 8'h74) begin
            w.phase = str_base;
          end else if (text_byte == 8'h75) begin
            w.phase     = str_base + 5'd2;
            w.hex_count = '0;
            w.hex_value = '0;
          end else begin
            w.err = jsv_pkg::ERR_ESCAPE;
          end
        end
        jsv_pkg::P_STR_HEX, jsv_pkg::P_KSTR_HEX: begin
          if (!hx[4]) begin
            w.err = jsv_pkg::ERR_HEX;
          end else begin
            w.hex_value = hex_shift;
            if (st.hex_count == 2'd3) begin
              w.hex_count = '0;
              if (hex_shift > 16'h007f) w.err   = jsv_pkg::ERR_NON_ASCII;
              else                      w.phase = str_base;
            end else begin
              w.hex_count = st.hex_count + 2'd1;
            end
          end
        end
        jsv_pkg::P_NUM_MINUS: begin
          if (text_byte == 8'h30) w.phase = jsv_pkg::P_NUM_ZERO;
          else if (dig)           w.phase = jsv_pkg::P_NUM_INT;
          else                    w.err   = jsv_pkg::ERR_NUMBER;
        end
        jsv_pkg::P_NUM_DOT, jsv_pkg::P_NUM_ESIGN: begin
          if (dig) begin
            w.phase = (st.phase == jsv_pkg::P_NUM_DOT) ? jsv_pkg::P_NUM_FRAC
                                                       : jsv_pkg::P_NUM_EXP;
          end else begin
            w.err = jsv_pkg::ERR_NUMBER;
          end
        end
        jsv_pkg::P_NUM_E: begin
          if (text_byte == 8'h2b || text_byte == 8'h2d) w.phase = jsv_pkg::P_NUM_ESIGN;
          else if (dig)                                 w.phase = jsv_pkg::P_NUM_EXP;
          else                                          w.err   = jsv_pkg::ERR_NUMBER;
        end
        jsv_pkg::P_NUM_ZERO, jsv_pkg::P_NUM_INT, jsv_pkg::P_NUM_FRAC, jsv_pkg::P_NUM_EXP: begin
          if (dig && st.phase != jsv_pkg::P_NUM_ZERO) begin
            w.phase = st.phase;
          end else if (text_byte == 8'h2e && st.phase != jsv_pkg::P_NUM_FRAC &&
                       st.phase != jsv_pkg::P_NUM_EXP) begin
            w.phase = jsv_pkg::P_NUM_DOT;
          end else if ((text_byte == 8'h65 || text_byte == 8'h45) &&
                       st.phase != jsv_pkg::P_NUM_EXP) begin
            w.phase = jsv_pkg::P_NUM_E;
          end else begin
            // the byte that ends a number is handled as what follows a value
            w.phase  = jsv_pkg::P_AFTER;
            do_after = 1'b1;
          end
        end
        jsv_pkg::P_LIT_TRUE, jsv_pkg::P_LIT_FALSE, jsv_pkg::P_LIT_NULL: begin
          if (st.lit_index >= lit_len || text_byte != lit_char(lit_kind, st.lit_index)) begin
            w.err = jsv_pkg::ERR_UNEXPECTED;
          end else if (st.lit_index + 3'd1 == lit_len) begin
            w.lit_index = '0;
            w.phase     = jsv_pkg::P_AFTER;
          end else begin
            w.lit_index = st.lit_index + 3'd1;
          end
        end
        default: begin
          w.err = jsv_pkg::ERR_UNEXPECTED;
        end
      endcase

      if (do_start) begin
        if (text_byte == 8'h22) begin
          w.phase = jsv_pkg::P_STR;
        end else if (text_byte == 8'h7b || text_byte == 8'h5b) begin
          if (st.level >= jsv_pkg::LEVEL_MAX) begin
            w.err = jsv_pkg::ERR_TOO_DEEP;
          end else begin
            push.en   = 1'b1;
            push.kind = (text_byte == 8'h7b);
            w.level   = st.level + 1'b1;
            w.phase   = (text_byte == 8'h7b) ? jsv_pkg::P_KEY_OR_CLOSE
                                             : jsv_pkg::P_VALUE_OR_CLOSE;
          end
        end else if (text_byte == 8'h2d) begin
          w.phase = jsv_pkg::P_NUM_MINUS;
        end else if (text_byte == 8'h30) begin
          w.phase = jsv_pkg::P_NUM_ZERO;
        end else if (dig) begin
          w.phase = jsv_pkg::P_NUM_INT;
        end else if (text_byte == 8'h74) begin
          w.phase     = jsv_pkg::P_LIT_TRUE;
          w.lit_index = 3'd1;
        end else if (text_byte == 8'h66) begin
          w.phase     = jsv_pkg::P_LIT_FALSE;
          w.lit_index = 3'd1;
        end else if (text_byte == 8'h6e) begin
          w.phase     = jsv_pkg::P_LIT_NULL;
          w.lit_index = 3'd1;
        end else begin
          w.err = jsv_pkg::ERR_UNEXPECTED;
        end
      end

      if (do_after && !ws) begin
        if (st.level == '0) begin
          w.err = jsv_pkg::ERR_TRAILING;
        end else if (text_byte == 8'h2c) begin
          w.phase = top_kind ? jsv_pkg::P_KEY : jsv_pkg::P_VALUE;
        end else if ((text_byte == 8'h7d && top_kind) || (text_byte == 8'h5d && !top_kind)) begin
          w.level = st.level - 1'b1;
        end else begin
          w.err = jsv_pkg::ERR_UNEXPECTED;
        end
      end

      if (w.err != jsv_pkg::ERR_NONE) w.err_offset = st.offset;
    end

    if (st.offset != jsv_pkg::OFFSET_MAX) w.offset = st.offset + 1'b1;

    done = (w.level == '0) &&
           ((w.phase == jsv_pkg::P_AFTER) || (w.phase == jsv_pkg::P_NUM_ZERO) ||
            (w.phase == jsv_pkg::P_NUM_INT) || (w.phase == jsv_pkg::P_NUM_FRAC) ||
            (w.phase == jsv_pkg::P_NUM_EXP));
    if (last_byte && w.err == jsv_pkg::ERR_NONE && !done) begin
      w.err        = jsv_pkg::ERR_EARLY_END;
      w.err_offset = w.offset;
    end

    res.valid  = (w.err == jsv_pkg::ERR_NONE);
    res.code   = w.err;
    res.offset = (w.err == jsv_pkg::ERR_NONE) ? 24'd0 : 24'(w.err_offset);

    // a finished document leaves the parser ready for the next one
    nx = last_byte ? jsv_pkg::ST_RESET : w;
  end

endmodule
